// File: rtl/pstb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstb_pkg
// Types and constants for the periodic software timer bank: request and
// result layouts, opcodes, and the control and status bundles of the bank.
// ----------------------------------------------------------------------------
package pstb_pkg;

    localparam int MASK_W  = 8;
    localparam int INDEX_W = 3;
    localparam int US_W    = 20;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;

    localparam logic [US_W:0]   USEC_PER_SEC      = 21'd1000000;
    localparam logic [US_W-1:0] TICK_PERIOD_RESET = 20'd1000;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [31:0]       period_ticks;
        logic [MASK_W-1:0] ack_mask;
    } cmd_item_t;

    typedef struct packed {
        logic [31:0]        tick_count;
        logic [31:0]        seconds;
        logic [US_W-1:0]    sub_second_us;
        logic [MASK_W-1:0]  fired_mask;
        logic [MASK_W-1:0]  elapsed_mask;
        logic [MASK_W-1:0]  acked_mask;
        logic [INDEX_W-1:0] added_index;
        logic               add_rejected;
    } res_item_t;

    typedef struct packed {
        logic tick;
        logic add;
        logic ack;
    } chan_cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0]  fired_mask;
        logic [MASK_W-1:0]  elapsed_mask;
        logic [MASK_W-1:0]  acked_mask;
        logic [INDEX_W-1:0] added_index;
        logic               add_rejected;
    } chan_status_t;

endpackage

// File: rtl/pstb_chan_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstb_chan_bank
// Bank of periodic timer channels: per-channel deadline and period, sticky
// elapsed bits and the fill count; due test, reload, add and acknowledge.
// ----------------------------------------------------------------------------
module pstb_chan_bank #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pstb_pkg::chan_cmd_t  cmd,
    input  logic [31:0]          tick_now,
    input  logic [31:0]          tick_new,
    input  logic [31:0]          period_ticks,
    input  logic [7:0]           ack_mask,
    output pstb_pkg::chan_status_t status
);
    import pstb_pkg::*;

    localparam int CW = $clog2(NUM_CHANNELS + 1);

    logic [31:0]             deadline_reg [NUM_CHANNELS];
    logic [31:0]             period_reg   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] elapsed_reg;
    logic [NUM_CHANNELS-1:0] elapsed_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;

    logic [NUM_CHANNELS-1:0] due;
    logic [NUM_CHANNELS-1:0] add_here;
    logic [NUM_CHANNELS-1:0] ackm;
    logic                    full;
    logic                    add_ok;

    assign ackm   = ack_mask[NUM_CHANNELS-1:0];
    assign full   = count_reg >= CW'(NUM_CHANNELS);
    assign add_ok = cmd.add && !full;

    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
        assign due[i]      = (count_reg > CW'(i)) && (tick_new >= deadline_reg[i]);
        assign add_here[i] = count_reg == CW'(i);

        always_ff @(posedge clk)
        begin
            if (cmd.tick && due[i])
            begin
                deadline_reg[i] <= deadline_reg[i] + period_reg[i];
            end
            else if (add_ok && add_here[i])
            begin
                deadline_reg[i] <= tick_now + period_ticks;
                period_reg[i]   <= period_ticks;
            end
        end
    end

    always_comb
    begin
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        if (cmd.tick)
        begin
            elapsed_next = elapsed_reg | due;
        end
        else if (add_ok)
        begin
            elapsed_next = elapsed_reg & ~add_here;
            count_next   = count_reg + CW'(1);
        end
        else if (cmd.ack)
        begin
            elapsed_next = elapsed_reg & ~ackm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
        end
    end

    always_comb
    begin
        status.fired_mask   = cmd.tick ? MASK_W'(due) : '0;
        status.elapsed_mask = MASK_W'(elapsed_next);
        status.acked_mask   = cmd.ack ? MASK_W'(elapsed_reg & ackm) : '0;
        status.added_index  = add_ok ? INDEX_W'(count_reg) : '0;
        status.add_rejected = cmd.add && full;
    end

endmodule

// File: rtl/periodic_software_timer_bank_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_software_timer_bank_top
// System tick counter with microsecond remainder and seconds, plus a bank of
// periodic timer channels that fire, reload and keep sticky elapsed bits.
// ----------------------------------------------------------------------------
// usage
//   cmd channel: one request per edge with cmd_valid high and cmd_stall low;
//     opcode tick advances the count and tests every channel in use, add
//     takes the next free channel, acknowledge reads and clears elapsed bits
//   res channel: exactly one result per request, in order, taken at an edge
//     with res_valid high and res_stall low
//   cfg channel: cfg_data is the tick period in microseconds, written when
//     cfg_valid is high (cfg_ready is always high); write only while idle
//   path: the request register and the result register bound one pass
//     of counter, compare and mask logic
//   throughput: one request per cycle sustained while res_stall is low
//   stall: a held result keeps its value; one more request is taken into
//     the request register, then cmd_stall rises until res moves
//   reset: counts, remainder, seconds, fill count and elapsed bits clear,
//     the tick period returns to 1000 us; channel deadlines and periods are
//     not reset and are only read once written
// ----------------------------------------------------------------------------
module periodic_software_timer_bank_top #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  pstb_pkg::cmd_item_t cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output pstb_pkg::res_item_t res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [19:0]         cfg_data
);
    import pstb_pkg::*;

    cmd_item_t       cmd_q_reg;
    logic            cmd_q_valid_reg;
    res_item_t       res_reg;
    res_item_t       res_next;
    logic            res_valid_reg;

    logic [US_W-1:0] tick_period_reg;
    logic [31:0]     tick_count_reg;
    logic [31:0]     tick_count_next;
    logic [31:0]     seconds_reg;
    logic [31:0]     seconds_next;
    logic [US_W-1:0] rem_reg;
    logic [US_W-1:0] rem_next;

    logic            advance;
    logic            accept;
    logic [31:0]     tick_inc;
    logic [US_W:0]   rem_sum;
    logic [US_W:0]   rem_adj;
    logic            carry;
    chan_cmd_t       chan_cmd;
    chan_status_t    chan_status;

    assign advance   = cmd_q_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = cmd_q_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_q_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            cmd_q_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            cmd_q_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_q_reg <= cmd;
        end
    end

    always_comb
    begin
        chan_cmd = '0;
        unique case (cmd_q_reg.opcode)
            OP_TICK: chan_cmd.tick = advance;
            OP_ADD:  chan_cmd.add  = advance;
            OP_ACK:  chan_cmd.ack  = advance;
            default: chan_cmd = '0;
        endcase
    end

    // tick arithmetic, at most one second carried per tick
    assign tick_inc = tick_count_reg + 32'd1;
    assign rem_sum  = {1'b0, rem_reg} + {1'b0, tick_period_reg};
    assign carry    = rem_sum >= USEC_PER_SEC;
    assign rem_adj  = carry ? rem_sum - USEC_PER_SEC : rem_sum;

    always_comb
    begin
        tick_count_next = tick_count_reg;
        seconds_next    = seconds_reg;
        rem_next        = rem_reg;
        if (chan_cmd.tick)
        begin
            tick_count_next = tick_inc;
            rem_next        = rem_adj[US_W-1:0];
            if (carry)
            begin
                seconds_next = seconds_reg + 32'd1;
            end
        end
    end

    pstb_chan_bank #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_chan_bank (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (chan_cmd),
        .tick_now     (tick_count_reg),
        .tick_new     (tick_inc),
        .period_ticks (cmd_q_reg.period_ticks),
        .ack_mask     (cmd_q_reg.ack_mask),
        .status       (chan_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_PERIOD_RESET;
            tick_count_reg  <= '0;
            seconds_reg     <= '0;
            rem_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tick_period_reg <= cfg_data;
            end
            tick_count_reg <= tick_count_next;
            seconds_reg    <= seconds_next;
            rem_reg        <= rem_next;
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        res_next.tick_count    = tick_count_next;
        res_next.seconds       = seconds_next;
        res_next.sub_second_us = rem_next;
        res_next.fired_mask    = chan_status.fired_mask;
        res_next.elapsed_mask  = chan_status.elapsed_mask;
        res_next.acked_mask    = chan_status.acked_mask;
        res_next.added_index   = chan_status.added_index;
        res_next.add_rejected  = chan_status.add_rejected;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (cmd_q_reg.opcode == OP_TICK) |=>
            res.tick_count == 32'($past(tick_count_reg) + 32'd1))
        else $error("tick result count is not previous count plus one");

    a_fired_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (res.fired_mask & ~res.elapsed_mask) == '0)
        else $error("fired channel without elapsed bit");

    a_acked_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (res.acked_mask & res.elapsed_mask) == '0)
        else $error("acknowledged channel still elapsed");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> cmd_q_valid_reg && res_valid_reg && res_stall)
        else $error("request stalled with room downstream");

endmodule

// File: bench/timer_bank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_bank_checker
// Watches the request, result and tick period channels of the timer bank,
// keeps its own copy of the tick counters and channel bank, and compares
// every result, field by field, in order against the predicted status.
// ----------------------------------------------------------------------------
module timer_bank_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_stall,
    input  pstb_pkg::cmd_item_t cmd,
    input  logic                res_valid,
    input  logic                res_stall,
    input  pstb_pkg::res_item_t res,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [19:0]         cfg_data,
    output int                  errors,
    output int                  pending,
    output int                  checked
);
    import pstb_pkg::*;

    localparam int CHANNELS = 8;

    logic [US_W-1:0]   tick_us;
    logic [31:0]       ticks;
    logic [31:0]       secs;
    logic [US_W-1:0]   rem_us;
    int unsigned       used;
    logic [31:0]       deadline [CHANNELS];
    logic [31:0]       period [CHANNELS];
    logic [MASK_W-1:0] elapsed;
    res_item_t         predicted_status [$];

    function automatic res_item_t advance_timer_bank(input cmd_item_t c);
        res_item_t r;
        logic [31:0] sum;
        r = '0;
        case (c.opcode)
            OP_TICK:
            begin
                ticks = ticks + 32'd1;
                sum = 32'(rem_us) + 32'(tick_us);
                if (sum >= 32'(USEC_PER_SEC))
                begin
                    sum = sum - 32'(USEC_PER_SEC);
                    secs = secs + 32'd1;
                end
                rem_us = sum[US_W-1:0];
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (i < used && ticks >= deadline[i])
                    begin
                        deadline[i] = deadline[i] + period[i];
                        elapsed[i] = 1'b1;
                        r.fired_mask[i] = 1'b1;
                    end
                end
            end
            OP_ADD:
            begin
                if (used >= CHANNELS)
                begin
                    r.add_rejected = 1'b1;
                end
                else
                begin
                    r.added_index = INDEX_W'(used);
                    period[used] = c.period_ticks;
                    deadline[used] = ticks + c.period_ticks;
                    elapsed[used] = 1'b0;
                    used = used + 1;
                end
            end
            OP_ACK:
            begin
                r.acked_mask = elapsed & c.ack_mask;
                elapsed = elapsed & ~c.ack_mask;
            end
            default:
            begin
            end
        endcase
        r.tick_count = ticks;
        r.seconds = secs;
        r.sub_second_us = rem_us;
        r.elapsed_mask = elapsed;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            tick_us = TICK_PERIOD_RESET;
            ticks = '0;
            secs = '0;
            rem_us = '0;
            used = 0;
            elapsed = '0;
            errors = 0;
            checked = 0;
            predicted_status.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tick_us = cfg_data;
            if (res_valid && !res_stall)
            begin
                if (predicted_status.size() == 0)
                begin
                    $error("result with no request waiting");
                    errors++;
                end
                else
                begin
                    want = predicted_status.pop_front();
                    checked++;
                    compare_field("tick_count", want.tick_count, res.tick_count);
                    compare_field("seconds", want.seconds, res.seconds);
                    compare_field("sub_second_us", 32'(want.sub_second_us),
                                  32'(res.sub_second_us));
                    compare_field("fired_mask", 32'(want.fired_mask), 32'(res.fired_mask));
                    compare_field("elapsed_mask", 32'(want.elapsed_mask),
                                  32'(res.elapsed_mask));
                    compare_field("acked_mask", 32'(want.acked_mask), 32'(res.acked_mask));
                    compare_field("added_index", 32'(want.added_index),
                                  32'(res.added_index));
                    compare_field("add_rejected", 32'(want.add_rejected),
                                  32'(res.add_rejected));
                end
            end
            if (cmd_valid && !cmd_stall)
                predicted_status.push_back(advance_timer_bank(cmd));
        end
        pending = predicted_status.size();
    end

endmodule

// File: bench/periodic_software_timer_bank_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_software_timer_bank_top_tb
// Drives tick, add, acknowledge and unused requests into the timer bank,
// first a directed run that fills the bank and overflows it, then random
// phases under several tick periods with random idling on both sides.
// ----------------------------------------------------------------------------
module periodic_software_timer_bank_top_tb;
    import pstb_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_SETTINGS = 8;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    cmd_item_t   cmd;
    logic        res_valid;
    logic        res_stall;
    res_item_t   res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [19:0] cfg_data;
    int          errors;
    int          pending;
    int          checked;
    int          sent = 0;
    int          idle_cycles = 0;

    periodic_software_timer_bank_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    timer_bank_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 20);
    endfunction

    function automatic cmd_item_t request(input logic [1:0] op, input logic [31:0] per,
                                          input logic [7:0] mask);
        cmd_item_t c;
        c.opcode = op;
        c.period_ticks = per;
        c.ack_mask = mask;
        return c;
    endfunction

    function automatic cmd_item_t random_request();
        int r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < 60)
            op = OP_TICK;
        else if (r < 85)
            op = OP_ACK;
        else if (r < 95)
            op = OP_ADD;
        else
            op = OP_NONE;
        return request(op, $urandom(), 8'($urandom_range(0, 255)));
    endfunction

    task automatic send(input cmd_item_t item, input int gap);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= item;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    // receiver: random stall runs, one long hold-off once traffic is flowing
    initial
    begin : receiver
        int left;
        int taken;
        bit held;
        left = 0;
        taken = 0;
        held = 1'b0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
                taken++;
            if (left > 0)
            begin
                left--;
            end
            else if (!held && taken >= 250 && cmd_valid)
            begin
                held = 1'b1;
                res_stall <= 1'b1;
                left = 80;
            end
            else if (res_stall)
            begin
                res_stall <= 1'b0;
                left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4)
                                                  : $urandom_range(10, 50);
            end
            else
            begin
                res_stall <= 1'b1;
                left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                  : $urandom_range(5, 25);
            end
        end
    end

    initial
    begin : stimulus
        logic [19:0] setting;
        bit quiet;
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty bank, fill all channels, overflow, acknowledges
        send(request(OP_NONE, 32'hFFFF_FFFF, 8'hFF), idle_gap());
        send(request(OP_ACK, 32'h0, 8'hFF), idle_gap());
        send(request(OP_TICK, 32'h0, 8'h00), idle_gap());
        send(request(OP_ADD, 32'h0, 8'h00), idle_gap());
        send(request(OP_ADD, 32'h1, 8'h00), idle_gap());
        send(request(OP_TICK, 32'h0, 8'h00), idle_gap());
        send(request(OP_ADD, 32'hFFFF_FFFF, 8'h00), idle_gap());
        send(request(OP_ADD, 32'h3, 8'h00), idle_gap());
        send(request(OP_TICK, 32'h0, 8'h00), idle_gap());
        send(request(OP_ACK, 32'h0, 8'h0F), idle_gap());
        send(request(OP_ADD, 32'h8000_0000, 8'h00), idle_gap());
        send(request(OP_ADD, 32'h2, 8'h00), idle_gap());
        send(request(OP_TICK, 32'h0, 8'h00), idle_gap());
        send(request(OP_TICK, 32'h0, 8'h00), idle_gap());
        send(request(OP_ADD, 32'h5, 8'h00), idle_gap());
        send(request(OP_ADD, 32'($urandom_range(4, 40)), 8'h00), idle_gap());
        send(request(OP_ADD, 32'h7, 8'hFF), idle_gap());
        send(request(OP_TICK, 32'h0, 8'h00), idle_gap());
        send(request(OP_TICK, 32'h0, 8'h00), idle_gap());
        send(request(OP_TICK, 32'h0, 8'h00), idle_gap());
        send(request(OP_ACK, 32'h0, 8'hAA), idle_gap());
        send(request(OP_ACK, 32'h0, 8'h55), idle_gap());
        send(request(OP_ACK, 32'h0, 8'h00), idle_gap());
        send(request(OP_NONE, $urandom(), 8'($urandom_range(0, 255))), idle_gap());

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            drain();
            case (p)
                0: setting = 20'd1000000;
                1: setting = 20'd1;
                2: setting = 20'hFFFFF;
                3: setting = 20'd0;
                4: setting = 20'd999999;
                5: setting = 20'h80000;
                6: setting = 20'd1000;
                default: setting = 20'($urandom_range(1, 1000000));
            endcase
            cfg_valid <= 1'b1;
            cfg_data <= setting;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send(random_request(), quiet ? 0 : idle_gap());
        end

        drain();
        repeat (5) @(posedge clk);
        $display("%0d requests sent under %0d tick period settings plus the reset value",
                 sent, NUM_SETTINGS);
        $display("%0d results compared, bank filled and overflowed, long result hold-off done",
                 checked);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
